// ===== hdl/sapm_pkg.sv =====
package sapm_pkg;

    // converter and duty scaling
    localparam int ADC_BITS        = 12;
    localparam int DUTY_MAX        = 100;
    localparam int DUTY_MIN        = 1;
    localparam int DUTY_W          = 7;
    localparam int INT_RAMP_BOTTOM = 1020;
    localparam int INT_RAMP_DIV    = 100;
    localparam int EXT_RAMP_SPAN   = 1000;

    // the external ramp divides by EXT_RAMP_SPAN / DUTY_MAX = 10: multiply by 205, shift by 11,
    // exact for every ramp offset below 1029
    localparam int EXT_RECIP       = 205;
    localparam int EXT_RECIP_SHIFT = 11;
    localparam int EXT_DIFF_W      = 10;

    // schedule and config widths
    localparam int TICK_BITS_DEF = 32;
    localparam int PERIOD_W      = 16;
    localparam int LEVEL_W       = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    // stream payload sizes
    localparam int IN_W        = 3 * ADC_BITS;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 3 * DUTY_W + 1 + 2 + 3;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_PERIOD   = 3'd0,
        CFG_CHECK_PERIOD    = 3'd1,
        CFG_BLINK_ONE       = 3'd2,
        CFG_BLINK_TWO       = 3'd3,
        CFG_BLINK_THREE     = 3'd4,
        CFG_POT_LEVEL       = 3'd5,
        CFG_INTERNAL_LEVEL  = 3'd6,
        CFG_EXTERNAL_LEVEL  = 3'd7
    } t_cfg_idx;

    // register reset values
    localparam logic [PERIOD_W-1:0] RST_SAMPLE_PERIOD  = 16'd10;
    localparam logic [PERIOD_W-1:0] RST_CHECK_PERIOD   = 16'd500;
    localparam logic [PERIOD_W-1:0] RST_BLINK_ONE      = 16'd1000;
    localparam logic [PERIOD_W-1:0] RST_BLINK_TWO      = 16'd400;
    localparam logic [PERIOD_W-1:0] RST_BLINK_THREE    = 16'd200;
    localparam logic [LEVEL_W-1:0]  RST_POT_LEVEL      = 12'd2000;
    localparam logic [LEVEL_W-1:0]  RST_INTERNAL_LEVEL = 12'd1100;
    localparam logic [LEVEL_W-1:0]  RST_EXTERNAL_LEVEL = 12'd1296;

    typedef struct packed {
        logic [PERIOD_W-1:0] sample_period;
        logic [PERIOD_W-1:0] check_period;
        logic [PERIOD_W-1:0] blink_one;
        logic [PERIOD_W-1:0] blink_two;
        logic [PERIOD_W-1:0] blink_three;
        logic [LEVEL_W-1:0]  pot_level;
        logic [LEVEL_W-1:0]  internal_level;
        logic [LEVEL_W-1:0]  external_level;
    } t_cfg;

endpackage

// ===== hdl/sensor_alarm_pwm_monitor.sv =====
// stages: the input register, then the state and result register
// throughput: one transaction per cycle unless m_axis_tready stalls the result; the whole
//   tick update is one pass of shallow logic
// reset: synchronous active-low; tick count, schedule stamps, alarm flags, LED and duties
//   clear, registers take their default periods and levels, both stages empty
module sensor_alarm_pwm_monitor #(
    parameter int TICK_BITS = sapm_pkg::TICK_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pot_sample[11:0], internal_temp_sample[23:12], external_temp_sample[35:24], zeros
    input  logic [sapm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pot_duty[6:0], internal_duty[13:7], external_duty[20:14], alarm_led[21],
    // alarm_count[23:22], alarm_flags[26:24], zeros
    output logic [sapm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [sapm_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [sapm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import sapm_pkg::*;

    t_cfg w_cfg;

    logic                r_in_valid;
    logic [ADC_BITS-1:0] r_pot;
    logic [ADC_BITS-1:0] r_itemp;
    logic [ADC_BITS-1:0] r_etemp;
    logic                w_adv;

    logic [TICK_BITS-1:0] r_tick, n_tick;
    logic [TICK_BITS-1:0] r_last_sample, n_last_sample;
    logic [TICK_BITS-1:0] r_last_check, n_last_check;
    logic [TICK_BITS-1:0] r_last_blink, n_last_blink;
    logic [2:0]           r_flags, n_flags;
    logic [1:0]           r_count, n_count;
    logic                 r_led, n_led;
    logic [DUTY_W-1:0]    r_pot_duty, n_pot_duty;
    logic [DUTY_W-1:0]    r_int_duty, n_int_duty;
    logic [DUTY_W-1:0]    r_ext_duty, n_ext_duty;
    logic                 r_out_valid;

    logic [DUTY_W-1:0]   w_pot_duty;
    logic [DUTY_W-1:0]   w_int_duty;
    logic [DUTY_W-1:0]   w_ext_duty;
    logic [PERIOD_W-1:0] w_blink_period;
    logic [2:0]          w_alarm;

    function automatic logic due(input logic [TICK_BITS-1:0] now,
                                 input logic [TICK_BITS-1:0] last,
                                 input logic [PERIOD_W-1:0]  period);
        logic [TICK_BITS-1:0] gap;
        gap = now - last;
        return gap >= TICK_BITS'(period);
    endfunction

    sapm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // handshake: the item moves on when the result slot is free or being drained
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_pot   <= s_axis_tdata[0 +: ADC_BITS];
            r_itemp <= s_axis_tdata[ADC_BITS +: ADC_BITS];
            r_etemp <= s_axis_tdata[2*ADC_BITS +: ADC_BITS];
        end
    end

    sapm_duty u_duty (
        .i_pot            (r_pot),
        .i_itemp          (r_itemp),
        .i_etemp          (r_etemp),
        .i_internal_level (w_cfg.internal_level),
        .i_external_level (w_cfg.external_level),
        .o_pot_duty       (w_pot_duty),
        .o_internal_duty  (w_int_duty),
        .o_external_duty  (w_ext_duty)
    );

    // raw alarm conditions
    assign w_alarm[0] = r_pot >= w_cfg.pot_level;
    assign w_alarm[1] = r_itemp >= w_cfg.internal_level;
    assign w_alarm[2] = r_etemp <= w_cfg.external_level;

    // tick update: duties, then alarm check, then LED
    always_comb begin
        n_tick        = r_tick + TICK_BITS'(1);
        n_last_sample = r_last_sample;
        n_last_check  = r_last_check;
        n_last_blink  = r_last_blink;
        n_pot_duty    = r_pot_duty;
        n_int_duty    = r_int_duty;
        n_ext_duty    = r_ext_duty;
        n_flags       = r_flags;
        n_led         = r_led;

        if (due(n_tick, r_last_sample, w_cfg.sample_period)) begin
            n_pot_duty    = w_pot_duty;
            n_int_duty    = w_int_duty;
            n_ext_duty    = w_ext_duty;
            n_last_sample = n_tick;
        end

        // the flag count always equals the number of set flags, so the guards
        // never block and the flags simply follow the conditions
        if (due(n_tick, r_last_check, w_cfg.check_period)) begin
            n_flags      = w_alarm;
            n_last_check = n_tick;
        end
        n_count = 2'(n_flags[0]) + 2'(n_flags[1]) + 2'(n_flags[2]);

        case (n_count)
            2'd1:    w_blink_period = w_cfg.blink_one;
            2'd2:    w_blink_period = w_cfg.blink_two;
            2'd3:    w_blink_period = w_cfg.blink_three;
            default: w_blink_period = '0;
        endcase

        if (n_count == 2'd0) begin
            n_led = 1'b0;
        end else if (due(n_tick, r_last_blink, w_blink_period)) begin
            n_led        = !r_led;
            n_last_blink = n_tick;
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= '0;
            r_last_sample <= '0;
            r_last_check  <= '0;
            r_last_blink  <= '0;
            r_flags       <= '0;
            r_count       <= '0;
            r_led         <= 1'b0;
            r_pot_duty    <= '0;
            r_int_duty    <= '0;
            r_ext_duty    <= '0;
        end else if (w_adv) begin
            r_tick        <= n_tick;
            r_last_sample <= n_last_sample;
            r_last_check  <= n_last_check;
            r_last_blink  <= n_last_blink;
            r_flags       <= n_flags;
            r_count       <= n_count;
            r_led         <= n_led;
            r_pot_duty    <= n_pot_duty;
            r_int_duty    <= n_int_duty;
            r_ext_duty    <= n_ext_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result transaction
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W-OUT_W)'(0), r_flags, r_count, r_led,
                            r_ext_duty, r_int_duty, r_pot_duty};

    // alarm count tracks the flags
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == 2'($countones(r_flags)))
        else $error("alarm count differs from set flags");

    // led is dark with no alarm
    a_led_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) |-> !r_led)
        else $error("alarm led lit with no alarm");

    // duties stay in range
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pot_duty <= DUTY_W'(DUTY_MAX) && r_int_duty <= DUTY_W'(DUTY_MAX)
        && r_ext_duty <= DUTY_W'(DUTY_MAX))
        else $error("duty above full scale");

    // the tick count advances by one per item
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_tick == $past(r_tick) + TICK_BITS'(1))
        else $error("tick count did not advance by one");

endmodule

// ===== hdl/sapm_cfg.sv =====
module sapm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sapm_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [sapm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output sapm_pkg::t_cfg                 o_cfg
);
    import sapm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode one register write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_SAMPLE_PERIOD:  n_cfg.sample_period  = i_cfg_wdata;
                CFG_CHECK_PERIOD:   n_cfg.check_period   = i_cfg_wdata;
                CFG_BLINK_ONE:      n_cfg.blink_one      = i_cfg_wdata;
                CFG_BLINK_TWO:      n_cfg.blink_two      = i_cfg_wdata;
                CFG_BLINK_THREE:    n_cfg.blink_three    = i_cfg_wdata;
                CFG_POT_LEVEL:      n_cfg.pot_level      = i_cfg_wdata[LEVEL_W-1:0];
                CFG_INTERNAL_LEVEL: n_cfg.internal_level = i_cfg_wdata[LEVEL_W-1:0];
                CFG_EXTERNAL_LEVEL: n_cfg.external_level = i_cfg_wdata[LEVEL_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_period  <= RST_SAMPLE_PERIOD;
            r_cfg.check_period   <= RST_CHECK_PERIOD;
            r_cfg.blink_one      <= RST_BLINK_ONE;
            r_cfg.blink_two      <= RST_BLINK_TWO;
            r_cfg.blink_three    <= RST_BLINK_THREE;
            r_cfg.pot_level      <= RST_POT_LEVEL;
            r_cfg.internal_level <= RST_INTERNAL_LEVEL;
            r_cfg.external_level <= RST_EXTERNAL_LEVEL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/sapm_duty.sv =====
module sapm_duty (
    input  logic [sapm_pkg::ADC_BITS-1:0] i_pot,
    input  logic [sapm_pkg::ADC_BITS-1:0] i_itemp,
    input  logic [sapm_pkg::ADC_BITS-1:0] i_etemp,
    input  logic [sapm_pkg::LEVEL_W-1:0]  i_internal_level,
    input  logic [sapm_pkg::LEVEL_W-1:0]  i_external_level,
    output logic [sapm_pkg::DUTY_W-1:0]   o_pot_duty,
    output logic [sapm_pkg::DUTY_W-1:0]   o_internal_duty,
    output logic [sapm_pkg::DUTY_W-1:0]   o_external_duty
);
    import sapm_pkg::*;

    localparam int POT_PROD_W = ADC_BITS + DUTY_W;
    localparam int EXT_TOP_W  = ADC_BITS + 1;
    localparam int EXT_PROD_W = EXT_DIFF_W + 8;

    logic [POT_PROD_W-1:0] w_pot_prod;
    logic [ADC_BITS-1:0]   w_int_diff;
    logic [EXT_TOP_W-1:0]  w_ext_top;
    logic [ADC_BITS-1:0]   w_ext_diff;
    logic [EXT_PROD_W-1:0] w_ext_prod;
    logic [DUTY_W-1:0]     w_ext_quot;

    // potentiometer: linear scale to percent
    assign w_pot_prod = POT_PROD_W'(i_pot) * POT_PROD_W'(DUTY_MAX);
    assign o_pot_duty = w_pot_prod[ADC_BITS +: DUTY_W];

    // internal: clamp low, clamp at level, ramp from the bottom in between
    // (scale DUTY_MAX / INT_RAMP_DIV is one, so the ramp is the offset itself)
    assign w_int_diff = i_itemp - ADC_BITS'(INT_RAMP_BOTTOM);
    always_comb begin
        if (i_itemp <= ADC_BITS'(INT_RAMP_BOTTOM)) begin
            o_internal_duty = DUTY_W'(DUTY_MIN);
        end else if (i_itemp >= i_internal_level) begin
            o_internal_duty = DUTY_W'(DUTY_MAX);
        end else if (w_int_diff > ADC_BITS'(DUTY_MAX)) begin
            o_internal_duty = DUTY_W'(DUTY_MAX);
        end else begin
            o_internal_duty = w_int_diff[DUTY_W-1:0];
        end
    end

    // external: inverted ramp over a fixed span above the level
    assign w_ext_top  = EXT_TOP_W'(i_external_level) + EXT_TOP_W'(EXT_RAMP_SPAN);
    assign w_ext_diff = i_etemp - i_external_level;
    assign w_ext_prod = EXT_PROD_W'(w_ext_diff[EXT_DIFF_W-1:0]) * EXT_PROD_W'(EXT_RECIP);
    assign w_ext_quot = w_ext_prod[EXT_RECIP_SHIFT +: DUTY_W];
    always_comb begin
        if (i_etemp <= i_external_level) begin
            o_external_duty = DUTY_W'(DUTY_MAX);
        end else if (EXT_TOP_W'(i_etemp) >= w_ext_top) begin
            o_external_duty = DUTY_W'(DUTY_MIN);
        end else begin
            o_external_duty = DUTY_W'(DUTY_MAX) - w_ext_quot;
        end
    end

endmodule

// ===== dv/sensor_alarm_pwm_monitor_tb.sv =====
module sensor_alarm_pwm_monitor_tb;

    import sapm_pkg::*;

    localparam int RST_CYCLES    = 8;
    localparam int SETTLE_CYCLES = 6;
    localparam int STUCK_LIMIT   = 3000;
    localparam int HOLD_LEN      = 300;
    localparam int N_REGS        = 8;
    localparam int N_PHASES      = 6;
    localparam int PHASE_ITEMS   = 155;
    localparam int SENSOR_COUNT  = 3;
    localparam int PRINT_LIMIT   = 40;
    localparam int RDG_MAX       = (1 << ADC_BITS) - 1;

    // one result word, last field in the lowest bits
    typedef struct packed {
        logic [2:0]        alarm_flags;
        logic [1:0]        alarm_count;
        logic              alarm_led;
        logic [DUTY_W-1:0] external_duty;
        logic [DUTY_W-1:0] internal_duty;
        logic [DUTY_W-1:0] pot_duty;
    } t_tick_result;

    localparam int RES_W = $bits(t_tick_result);

    typedef enum logic {
        ROW_TICK,
        ROW_WRITE
    } t_row_kind;

    typedef struct {
        t_row_kind           kind;
        t_cfg_idx            reg_idx;
        logic [15:0]         reg_val;
        logic [ADC_BITS-1:0] pot;
        logic [ADC_BITS-1:0] itemp;
        logic [ADC_BITS-1:0] etemp;
        bit                  known;
        t_tick_result        want;
    } t_plan_row;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;

    // register copies used by the tick predictor
    logic [PERIOD_W-1:0] period_sample = RST_SAMPLE_PERIOD;
    logic [PERIOD_W-1:0] period_check  = RST_CHECK_PERIOD;
    logic [PERIOD_W-1:0] period_blink1 = RST_BLINK_ONE;
    logic [PERIOD_W-1:0] period_blink2 = RST_BLINK_TWO;
    logic [PERIOD_W-1:0] period_blink3 = RST_BLINK_THREE;
    logic [LEVEL_W-1:0]  level_pot     = RST_POT_LEVEL;
    logic [LEVEL_W-1:0]  level_int     = RST_INTERNAL_LEVEL;
    logic [LEVEL_W-1:0]  level_ext     = RST_EXTERNAL_LEVEL;

    // predicted block state
    logic [31:0]       tick_cnt     = '0;
    logic [31:0]       duty_stamp   = '0;
    logic [31:0]       check_stamp  = '0;
    logic [31:0]       blink_stamp  = '0;
    logic [2:0]        alarm_bits   = '0;
    logic [1:0]        alarm_total  = '0;
    logic              led_state    = 1'b0;
    logic [DUTY_W-1:0] pot_pct      = '0;
    logic [DUTY_W-1:0] internal_pct = '0;
    logic [DUTY_W-1:0] external_pct = '0;

    t_tick_result pending_results[$];
    t_plan_row    plan[$];
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           stall_pct      = 0;
    int           hold_seq       = 0;
    int           hold_seen      = 0;
    int           hold_left      = 0;
    int           stuck_cycles   = 0;

    sensor_alarm_pwm_monitor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // pot_sample, internal_temp_sample, external_temp_sample, zeros
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // pot_duty, internal_duty, external_duty, alarm_led, alarm_count, alarm_flags, zeros
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        end
    endtask

    // alarm flag update, set or cleared per reading, count kept equal to the number of set flags
    function automatic void judge_alarm(input bit alarm, input int pos);
        if (alarm) begin
            if (alarm_total < SENSOR_COUNT && !alarm_bits[pos]) begin
                alarm_total   = alarm_total + 1'b1;
                alarm_bits[pos] = 1'b1;
            end
        end else if (alarm_total > 0 && alarm_bits[pos]) begin
            alarm_total   = alarm_total - 1'b1;
            alarm_bits[pos] = 1'b0;
        end
    endfunction

    // one millisecond tick: duties, then alarm check, then led
    function automatic t_tick_result advance_tick(input logic [ADC_BITS-1:0] pot,
                                                  input logic [ADC_BITS-1:0] itemp,
                                                  input logic [ADC_BITS-1:0] etemp);
        t_tick_result r;
        logic [31:0]  blink_len;
        int           ramp;
        int           ext_floor;
        tick_cnt = tick_cnt + 1;

        // duty recomputation
        if (tick_cnt - duty_stamp >= 32'(period_sample)) begin
            pot_pct = DUTY_W'((int'(pot) * DUTY_MAX) >> ADC_BITS);
            if (int'(itemp) <= INT_RAMP_BOTTOM) begin
                internal_pct = DUTY_W'(DUTY_MIN);
            end else if (itemp >= level_int) begin
                internal_pct = DUTY_W'(DUTY_MAX);
            end else begin
                ramp = (int'(itemp) - INT_RAMP_BOTTOM) * DUTY_MAX / INT_RAMP_DIV;
                internal_pct = DUTY_W'((ramp > DUTY_MAX) ? DUTY_MAX : ramp);
            end
            ext_floor = int'(level_ext);
            if (int'(etemp) <= ext_floor) begin
                external_pct = DUTY_W'(DUTY_MAX);
            end else if (int'(etemp) >= ext_floor + EXT_RAMP_SPAN) begin
                external_pct = DUTY_W'(DUTY_MIN);
            end else begin
                ramp = (int'(etemp) - ext_floor) * DUTY_MAX / EXT_RAMP_SPAN;
                external_pct = DUTY_W'((ramp > DUTY_MAX) ? 0 : DUTY_MAX - ramp);
            end
            duty_stamp = tick_cnt;
        end

        // alarm evaluation
        if (tick_cnt - check_stamp >= 32'(period_check)) begin
            judge_alarm(pot >= level_pot, 0);
            judge_alarm(itemp >= level_int, 1);
            judge_alarm(etemp <= level_ext, 2);
            check_stamp = tick_cnt;
        end

        // led blink at the count-selected interval
        case (alarm_total)
            2'd1:    blink_len = 32'(period_blink1);
            2'd2:    blink_len = 32'(period_blink2);
            2'd3:    blink_len = 32'(period_blink3);
            default: blink_len = '0;
        endcase
        if (alarm_total == 0) begin
            led_state = 1'b0;
        end else if (tick_cnt - blink_stamp >= blink_len) begin
            led_state   = ~led_state;
            blink_stamp = tick_cnt;
        end

        r.pot_duty      = pot_pct;
        r.internal_duty = internal_pct;
        r.external_duty = external_pct;
        r.alarm_led     = led_state;
        r.alarm_count   = alarm_total;
        r.alarm_flags   = alarm_bits;
        return r;
    endfunction

    // directed table builders
    function automatic void plan_write(input t_cfg_idx idx, input logic [15:0] val);
        t_plan_row row;
        row         = '{kind: ROW_WRITE, reg_idx: CFG_SAMPLE_PERIOD, default: '0};
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        plan.push_back(row);
    endfunction

    function automatic void plan_tick(input int pot, input int itemp, input int etemp);
        t_plan_row row;
        row       = '{kind: ROW_TICK, reg_idx: CFG_SAMPLE_PERIOD, default: '0};
        row.kind  = ROW_TICK;
        row.pot   = ADC_BITS'(pot);
        row.itemp = ADC_BITS'(itemp);
        row.etemp = ADC_BITS'(etemp);
        plan.push_back(row);
    endfunction

    // tick with a result read straight off the spec, no alarms and led low
    function automatic void plan_known(input int pot, input int itemp, input int etemp,
                                       input int pd, input int id, input int ed);
        plan_tick(pot, itemp, etemp);
        plan[$].known              = 1'b1;
        plan[$].want               = '0;
        plan[$].want.pot_duty      = DUTY_W'(pd);
        plan[$].want.internal_duty = DUTY_W'(id);
        plan[$].want.external_duty = DUTY_W'(ed);
    endfunction

    // random reading, biased around two points of interest
    function automatic logic [ADC_BITS-1:0] pick_reading(input int near_a, input int near_b);
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
            v = near_a + int'($urandom_range(0, 40)) - 20;
        end else if (roll < 50) begin
            v = near_b + int'($urandom_range(0, 40)) - 20;
        end else if (roll < 85) begin
            v = int'($urandom_range(0, RDG_MAX));
        end else begin
            v = ($urandom_range(0, 1) != 0) ? RDG_MAX : 0;
        end
        if (v < 0) v = 0;
        if (v > RDG_MAX) v = RDG_MAX;
        return ADC_BITS'(v);
    endfunction

    // present one tick, predict it on acceptance
    task automatic send_tick(input logic [ADC_BITS-1:0] pot, input logic [ADC_BITS-1:0] itemp,
                             input logic [ADC_BITS-1:0] etemp, input bit known,
                             input t_tick_result want_known);
        t_tick_result want;
        i_cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - IN_W){1'b0}}, etemp, itemp, pot};
        do @(posedge i_clk); while (!s_axis_tready);
        want = advance_tick(pot, itemp, etemp);
        pending_results.push_back(known ? want_known : want);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_SAMPLE_PERIOD:  period_sample = val;
            CFG_CHECK_PERIOD:   period_check  = val;
            CFG_BLINK_ONE:      period_blink1 = val;
            CFG_BLINK_TWO:      period_blink2 = val;
            CFG_BLINK_THREE:    period_blink3 = val;
            CFG_POT_LEVEL:      level_pot     = val[LEVEL_W-1:0];
            CFG_INTERNAL_LEVEL: level_int     = val[LEVEL_W-1:0];
            CFG_EXTERNAL_LEVEL: level_ext     = val[LEVEL_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
        t_tick_result got;
        t_tick_result want;
        got = word[RES_W-1:0];
        if (pending_results.size() == 0) begin
            report_mismatch("result with no tick pending", int'(got), 0);
            return;
        end
        want = pending_results.pop_front();
        if (got.pot_duty != want.pot_duty)
            report_mismatch("pot_duty", got.pot_duty, want.pot_duty);
        if (got.internal_duty != want.internal_duty)
            report_mismatch("internal_duty", got.internal_duty, want.internal_duty);
        if (got.external_duty != want.external_duty)
            report_mismatch("external_duty", got.external_duty, want.external_duty);
        if (got.alarm_led != want.alarm_led)
            report_mismatch("alarm_led", got.alarm_led, want.alarm_led);
        if (got.alarm_count != want.alarm_count)
            report_mismatch("alarm_count", got.alarm_count, want.alarm_count);
        if (got.alarm_flags != want.alarm_flags)
            report_mismatch("alarm_flags", got.alarm_flags, want.alarm_flags);
        if (word[OUT_TDATA_W-1:RES_W] != '0)
            report_mismatch("tdata padding", int'(word[OUT_TDATA_W-1:RES_W]), 0);
    endtask

    // result side: random stalls, long hold-off on request, checking
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen     <= hold_seq;
            hold_left     <= HOLD_LEN;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            check_result(m_axis_tdata);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_cfg_idx    reg_idx;
        logic [15:0] reg_val;
        int          roll;

        // duties read zero until the first recomputation at tick ten
        plan_known(RDG_MAX, RDG_MAX, RDG_MAX, 0, 0, 0);
        plan_known(0, 0, 0, 0, 0, 0);
        plan_known('hAAA, 'h555, 'hAAA, 0, 0, 0);
        plan_known('h555, 'hAAA, 'h555, 0, 0, 0);
        plan_known(2000, 1100, 1296, 0, 0, 0);
        plan_known(1999, 1020, 2296, 0, 0, 0);
        plan_known(RDG_MAX, 1021, 1297, 0, 0, 0);
        plan_known(0, RDG_MAX, 0, 0, 0, 0);
        plan_known(1, 2, 3, 0, 0, 0);
        plan_tick(RDG_MAX, 0, RDG_MAX);
        // zero sample period recomputes every tick, alarm check pushed far out
        plan_write(CFG_SAMPLE_PERIOD, 16'd0);
        plan_write(CFG_CHECK_PERIOD, 16'hFFFF);
        plan_known(RDG_MAX, RDG_MAX, RDG_MAX, 99, DUTY_MAX, DUTY_MIN);
        plan_known(0, 0, 0, 0, DUTY_MIN, DUTY_MAX);
        plan_tick(1050, 1050, 1796);
        plan_tick(2047, 1119, 2295);
        plan_tick(RDG_MAX, 1120, 1297);
        // alarms checked every tick, fast blinking for each count
        plan_write(CFG_CHECK_PERIOD, 16'd0);
        plan_write(CFG_BLINK_ONE, 16'd0);
        plan_write(CFG_BLINK_TWO, 16'd1);
        plan_write(CFG_BLINK_THREE, 16'd2);
        plan_tick(2000, 0, RDG_MAX);
        plan_tick(2000, 1100, RDG_MAX);
        plan_tick(2000, 1100, 1296);
        plan_tick(2000, 1100, 1296);
        plan_tick(0, 0, RDG_MAX);
        plan_tick(1999, 1099, 1297);
        plan_tick(RDG_MAX, RDG_MAX, 0);
        plan_tick(RDG_MAX, RDG_MAX, 0);
        plan_tick(0, RDG_MAX, RDG_MAX);

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (plan[n]) begin
            if (plan[n].kind == ROW_WRITE) begin
                if (n == 0 || plan[n-1].kind != ROW_WRITE) wait_results_done();
                write_reg(plan[n].reg_idx, plan[n].reg_val);
            end else begin
                send_tick(plan[n].pot, plan[n].itemp, plan[n].etemp, plan[n].known,
                          plan[n].want);
            end
        end

        // random phases, each with its own settings and idling mix
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_results_done();
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 60; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 60; end
                default: begin send_idle_pct = 37; stall_pct <= 37; end
            endcase
            for (int r = 0; r < N_REGS; r++) begin
                reg_idx = t_cfg_idx'(r);
                if (ph == 1) begin
                    // everything fires every tick, every sensor always in alarm
                    if (reg_idx == CFG_EXTERNAL_LEVEL) reg_val = 16'h0FFF;
                    else if (reg_idx >= CFG_POT_LEVEL) reg_val = 16'hF000;
                    else reg_val = 16'h0000;
                end else if (ph == 2) begin
                    // longest periods, alarms only at the reading extremes
                    if (reg_idx == CFG_EXTERNAL_LEVEL) reg_val = 16'hF000;
                    else if (reg_idx == CFG_INTERNAL_LEVEL) reg_val = 16'h0FFF;
                    else reg_val = 16'hFFFF;
                end else if (reg_idx <= CFG_BLINK_THREE) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70) reg_val = 16'($urandom_range(0, 12));
                    else if (roll < 90) reg_val = 16'($urandom_range(13, 200));
                    else reg_val = 16'($urandom_range(0, 65535));
                end else begin
                    reg_val = 16'($urandom_range(0, 65535));
                end
                write_reg(reg_idx, reg_val);
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // long result-side hold-off while ticks keep coming
                if (ph == 0 && k == 20) hold_seq <= hold_seq + 1;
                // sender pause until everything is back
                if (ph == 3 && k == 80) wait_results_done();
                send_tick(pick_reading(int'(level_pot), 1 << (ADC_BITS - 1)),
                          pick_reading(int'(level_int), INT_RAMP_BOTTOM),
                          pick_reading(int'(level_ext), int'(level_ext) + EXT_RAMP_SPAN),
                          1'b0, '0);
            end
        end

        wait_results_done();
        if (pending_results.size() != 0) begin
            report_mismatch("results never returned", pending_results.size(), 0);
        end
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sapm_pkg.sv
hdl/sapm_cfg.sv
hdl/sapm_duty.sv
hdl/sensor_alarm_pwm_monitor.sv
dv/sensor_alarm_pwm_monitor_tb.sv
